// File: rtl/core/gwm_pkg.sv
// Shared constants, codes and types for the glob wildcard matcher.
package gwm_pkg;

   // Pattern store depth and the widths that follow from it.
   localparam int MAX_ELEMENTS = 32;
   localparam int POS_W        = MAX_ELEMENTS + 1;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   // Command codes carried on the request channel.
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_TEXT   = 2'd2;
   localparam cmd_type CMD_END    = 2'd3;

   // Pattern element kinds.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LITERAL = 2'd0;
   localparam kind_type KIND_ANY     = 2'd1;
   localparam kind_type KIND_STAR    = 2'd2;

   // Special pattern characters.
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_QUEST  = 8'h3F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   typedef logic [POS_W-1:0] pos_type;

endpackage

// File: rtl/core/glob_wildcard_matcher.sv
// Glob wildcard matcher: pattern store and bit-vector matching automaton.
//
// Usage: every request transaction carries a command in req_tuser and a byte
// in req_tdata. Clear empties the stored pattern, append adds one pattern
// byte (star, question mark and backslash escapes are decoded on the way in),
// text feeds one byte of the text under test, and end closes the text. Only
// an end transaction produces a response: rsp_tdata bit 0 is set when the whole
// text matched, bit 1 when the pattern overflowed the store (matched is then
// zero). The pattern is kept across texts; each end restarts the matcher.
// A request is registered on acceptance and processed from the input register.
// Throughput: one transaction per cycle of any kind; an end transaction waits
// while a response is held. The whole position set, star closure included,
// is updated combinationally; the closure is an adder carry chain across the
// element positions. Reset clears the pattern, the escape and overflow flags
// and returns the position set to its start position. When the receiver
// stalls, the response waits in its output register; clear, append and text
// transactions keep flowing past it, and only the next end transaction waits
// for the output register to drain.
module glob_wildcard_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   localparam int MaxEl = gwm_pkg::MAX_ELEMENTS;
   localparam int CntW  = gwm_pkg::CNT_W;
   localparam int PosW  = gwm_pkg::POS_W;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   gwm_pkg::cmd_type   in_cmd_ff;
   logic [7:0]         in_byte_ff;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic               out_matched_ff, out_matched_in;
   logic               out_ovf_ff, out_ovf_in;

   // Pattern store and matcher state.
   gwm_pkg::kind_type  kind_ff [MaxEl];
   gwm_pkg::kind_type  kind_in [MaxEl];
   logic [7:0]         byte_ff [MaxEl];
   logic [7:0]         byte_in [MaxEl];
   logic [CntW-1:0]    count_ff, count_in;
   logic               esc_ff, esc_in;
   logic               ovf_ff, ovf_in;
   gwm_pkg::pos_type   act_ff, act_in;

   // Element writes of the current transaction, up to two.
   logic               a_en, b_en;
   gwm_pkg::kind_type  a_kind, b_kind;
   logic [7:0]         a_byte, b_byte;
   logic [CntW:0]      idx_b;
   logic               a_fit, b_fit, ovf_new;
   logic               esc_upd;

   // Matching view of the updated pattern.
   gwm_pkg::pos_type   star_vec, hit_vec, clos, adv;
   logic               end_hit;
   logic               fire;
   logic               is_wild;

   // Star closure as a carry chain: a carry enters position j when an active
   // star sits below it with only stars in between.
   function automatic gwm_pkg::pos_type closure(gwm_pkg::pos_type s,
                                                gwm_pkg::pos_type star);
      gwm_pkg::pos_type sum;
      sum = (s & star) + star;
      return s | (sum ^ (star & ~s));
   endfunction

   // Handshake: the processing stage stalls only for an end transaction while
   // a response is still waiting.
   assign fire = in_valid_ff &&
                 (!out_valid_ff || rsp_tready || (in_cmd_ff != gwm_pkg::CMD_END));
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Decode the element writes that this transaction makes.
   assign is_wild = (in_byte_ff == gwm_pkg::CHAR_STAR) ||
                    (in_byte_ff == gwm_pkg::CHAR_QUEST);

   always_comb begin
      gwm_pkg::kind_type norm_kind;
      logic              norm_en;
      norm_en   = 1'b1;
      norm_kind = gwm_pkg::KIND_LITERAL;
      if (in_byte_ff == gwm_pkg::CHAR_STAR) begin
         norm_kind = gwm_pkg::KIND_STAR;
      end else if (in_byte_ff == gwm_pkg::CHAR_QUEST) begin
         norm_kind = gwm_pkg::KIND_ANY;
      end else if (in_byte_ff == gwm_pkg::CHAR_BSLASH) begin
         norm_en = 1'b0;
      end

      a_en    = 1'b0;
      a_kind  = gwm_pkg::KIND_LITERAL;
      a_byte  = gwm_pkg::CHAR_BSLASH;
      b_en    = 1'b0;
      b_kind  = norm_kind;
      b_byte  = in_byte_ff;
      esc_upd = 1'b0;
      unique case (in_cmd_ff)
         gwm_pkg::CMD_CLEAR: begin
            esc_upd = 1'b0;
         end
         gwm_pkg::CMD_APPEND: begin
            if (esc_ff && is_wild) begin
               // Escaped wildcard becomes a literal.
               a_en   = 1'b1;
               a_byte = in_byte_ff;
            end else if (esc_ff) begin
               // The held backslash is a literal; the byte is then decoded.
               a_en    = 1'b1;
               b_en    = norm_en;
               esc_upd = !norm_en;
            end else begin
               a_en    = norm_en;
               a_kind  = norm_kind;
               a_byte  = in_byte_ff;
               esc_upd = !norm_en;
            end
         end
         gwm_pkg::CMD_TEXT, gwm_pkg::CMD_END: begin
            // A dangling backslash is stored as a literal first.
            a_en = esc_ff;
         end
         default: begin
            esc_upd = 1'b0;
         end
      endcase
   end

   // Place the writes and track overflow of the store.
   assign a_fit   = a_en && (count_ff < CntW'(MaxEl));
   assign idx_b   = {1'b0, count_ff} + (CntW + 1)'(a_en);
   assign b_fit   = b_en && (idx_b < (CntW + 1)'(MaxEl));
   assign ovf_new = (a_en && !a_fit) || (b_en && !b_fit);

   always_comb begin
      for (int i = 0; i < MaxEl; i++) begin
         kind_in[i] = kind_ff[i];
         byte_in[i] = byte_ff[i];
         if (a_fit && (count_ff == CntW'(i))) begin
            kind_in[i] = a_kind;
            byte_in[i] = a_byte;
         end
         if (b_fit && (idx_b == (CntW + 1)'(i))) begin
            kind_in[i] = b_kind;
            byte_in[i] = b_byte;
         end
      end
      count_in = count_ff + CntW'(a_fit) + CntW'(b_fit);
   end

   // Per-position star and byte-match vectors over the updated pattern.
   always_comb begin
      star_vec = '0;
      hit_vec  = '0;
      for (int i = 0; i < MaxEl; i++) begin
         if (CntW'(i) < count_in) begin
            star_vec[i] = (kind_in[i] == gwm_pkg::KIND_STAR);
            hit_vec[i]  = (kind_in[i] == gwm_pkg::KIND_ANY) ||
                          ((kind_in[i] == gwm_pkg::KIND_LITERAL) &&
                           (byte_in[i] == in_byte_ff));
         end
      end
   end

   // Advance the position set by one text byte.
   assign clos    = closure(act_ff, star_vec);
   assign adv     = (clos & star_vec) | ((clos & hit_vec) << 1);
   assign end_hit = clos[count_in];

   // Next state of the matcher.
   always_comb begin
      esc_in = esc_ff;
      ovf_in = ovf_ff;
      act_in = act_ff;
      if (fire) begin
         unique case (in_cmd_ff)
            gwm_pkg::CMD_CLEAR: begin
               esc_in = 1'b0;
               ovf_in = 1'b0;
               act_in = PosW'(1);
            end
            gwm_pkg::CMD_APPEND: begin
               esc_in = esc_upd;
               ovf_in = ovf_ff || ovf_new;
            end
            gwm_pkg::CMD_TEXT: begin
               esc_in = 1'b0;
               ovf_in = ovf_ff || ovf_new;
               act_in = adv;
            end
            gwm_pkg::CMD_END: begin
               esc_in = 1'b0;
               ovf_in = ovf_ff || ovf_new;
               act_in = PosW'(1);
            end
            default: begin
               act_in = act_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         esc_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         act_ff   <= PosW'(1);
      end else begin
         if (fire) begin
            count_ff <= (in_cmd_ff == gwm_pkg::CMD_CLEAR) ? '0 : count_in;
         end
         esc_ff <= esc_in;
         ovf_ff <= ovf_in;
         act_ff <= act_in;
      end
   end

   // Pattern store entries.
   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < MaxEl; i++) begin
            kind_ff[i] <= kind_in[i];
            byte_ff[i] <= byte_in[i];
         end
      end
   end

   // Response register.
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_matched_in = out_matched_ff;
      out_ovf_in     = out_ovf_ff;
      if (fire && (in_cmd_ff == gwm_pkg::CMD_END)) begin
         out_valid_in   = 1'b1;
         out_ovf_in     = ovf_ff || ovf_new;
         out_matched_in = end_hit && !(ovf_ff || ovf_new);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_matched_ff <= out_matched_in;
      out_ovf_ff     <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ovf_ff, out_matched_ff};

endmodule
